// ===== rtl/hti_pkg.sv =====
// Shared types, widths, constants and helpers of the Hermite trajectory interpolator.
package hti_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int DT_W   = 31;
    localparam int X_W    = 32;
    localparam int K_W    = 18;
    localparam int TOL_W  = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd17;

    localparam int VDT_W  = 47;   // floor(v*dt / 2^16)
    localparam int SPAN_W = 33;   // x2 - x1, v2 - v1
    localparam int CO_W   = 52;   // polynomial coefficients, 3A included
    localparam int ACC_W  = 62;   // Horner values, within +-2^60
    localparam int SUM_W  = 63;   // one add beyond that
    localparam int SPLIT  = 24;   // hi/lo split of the K product
    localparam int HI_W   = ACC_W - SPLIT;
    localparam int PH_W   = HI_W + K_W;
    localparam int PL_W   = SPLIT + 1 + K_W;
    localparam int TPR_W  = TOL_W + SPAN_W;
    localparam int THR_W  = TPR_W - SPLIT + 1;

    localparam int DIV_W      = 32;
    localparam int DIV_PER    = 2;
    localparam int DIV_STAGES = DIV_W / DIV_PER;

    localparam logic signed [SUM_W-1:0] LIM  = {3'b001, 60'd0};
    localparam logic signed [SUM_W-1:0] NLIM = -LIM;

    typedef enum logic [1:0] {
        ORD_AUTO   = 2'd0,
        ORD_LINEAR = 2'd1,
        ORD_QUAD   = 2'd2,
        ORD_CUBIC  = 2'd3
    } t_order;

    // everything a Horner step needs besides the two running values
    typedef struct packed {
        logic signed [K_W-1:0]   k;
        logic [2:0][CO_W-1:0]    pc;
        logic [2:0][CO_W-1:0]    vc;
        logic [DT_W-1:0]         dt;
        t_order                  order;
    } t_job;

    function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] c;
        if (x > LIM) c = LIM;
        else if (x < NLIM) c = NLIM;
        else c = x;
        return c[ACC_W-1:0];
    endfunction

    function automatic logic [X_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic [X_W-1:0] r;
        if (x > ACC_W'(64'sh7FFF_FFFF)) r = 32'h7FFF_FFFF;
        else if (x < -ACC_W'(64'sh8000_0000)) r = 32'h8000_0000;
        else r = x[X_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/hti_horner_step.sv =====
// One Horner step t = clamp(floor(t*K / 2^FB) + c) on the position and velocity lanes.
module hti_horner_step #(
    parameter int FRACTION_BITS = hti_pkg::FRACTION_BITS_DEF,
    parameter int STEP          = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  hti_pkg::t_job                       i_job,
    input  logic signed [hti_pkg::ACC_W-1:0]    i_pacc,
    input  logic signed [hti_pkg::ACC_W-1:0]    i_vacc,
    output logic                                o_valid,
    output hti_pkg::t_job                       o_job,
    output logic signed [hti_pkg::ACC_W-1:0]    o_pacc,
    output logic signed [hti_pkg::ACC_W-1:0]    o_vacc
);

    localparam int SHIFT = hti_pkg::SPLIT - FRACTION_BITS;
    localparam logic signed [hti_pkg::SUM_W-1:0] PLIM = hti_pkg::LIM >>> SHIFT;

    // hi part saturates before it is scaled, then the lo part is added
    function automatic logic signed [hti_pkg::ACC_W-1:0] combine(
        input logic signed [hti_pkg::PH_W-1:0] ph,
        input logic signed [hti_pkg::PL_W-1:0] pl
    );
        logic signed [hti_pkg::SUM_W-1:0] pe;
        logic signed [hti_pkg::SUM_W-1:0] r;
        logic signed [hti_pkg::SUM_W-1:0] s;
        pe = hti_pkg::SUM_W'(ph);
        if (pe > PLIM) r = hti_pkg::LIM;
        else if (pe < -PLIM) r = hti_pkg::NLIM;
        else r = pe <<< SHIFT;
        s = r + (hti_pkg::SUM_W'(pl) >>> FRACTION_BITS);
        return hti_pkg::clamp_acc(s);
    endfunction

    logic                               r_v1, r_v2, r_v3;
    hti_pkg::t_job                      r_job1, r_job2, r_job3;
    logic signed [hti_pkg::PH_W-1:0]    r_pph, r_vph;
    logic signed [hti_pkg::PL_W-1:0]    r_ppl, r_vpl;
    logic signed [hti_pkg::ACC_W-1:0]   r_pm, r_vm, r_pout, r_vout;
    logic signed [hti_pkg::ACC_W-1:0]   n_pout, n_vout;

    always_comb begin
        n_pout = hti_pkg::clamp_acc(hti_pkg::SUM_W'(r_pm)
                 + hti_pkg::SUM_W'($signed(r_job2.pc[STEP])));
        n_vout = hti_pkg::clamp_acc(hti_pkg::SUM_W'(r_vm)
                 + hti_pkg::SUM_W'($signed(r_job2.vc[STEP])));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pph  <= $signed(i_pacc[hti_pkg::ACC_W-1:hti_pkg::SPLIT]) * $signed(i_job.k);
        r_ppl  <= $signed({1'b0, i_pacc[hti_pkg::SPLIT-1:0]}) * $signed(i_job.k);
        r_vph  <= $signed(i_vacc[hti_pkg::ACC_W-1:hti_pkg::SPLIT]) * $signed(i_job.k);
        r_vpl  <= $signed({1'b0, i_vacc[hti_pkg::SPLIT-1:0]}) * $signed(i_job.k);
        r_job1 <= i_job;
        r_pm   <= combine(r_pph, r_ppl);
        r_vm   <= combine(r_vph, r_vpl);
        r_job2 <= r_job1;
        r_pout <= n_pout;
        r_vout <= n_vout;
        r_job3 <= r_job2;
    end

    assign o_valid = r_v3;
    assign o_job   = r_job3;
    assign o_pacc  = r_pout;
    assign o_vacc  = r_vout;

endmodule

// ===== rtl/hti_divider.sv =====
// Pipelined velocity divide by dt, two quotient bits a stage, with saturation and final muxing.
module hti_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [hti_pkg::ACC_W-1:0]    i_vacc,
    input  logic signed [hti_pkg::ACC_W-1:0]    i_pacc,
    input  hti_pkg::t_order                     i_order,
    input  logic [hti_pkg::DT_W-1:0]            i_dt,
    output logic                                o_valid,
    output logic [hti_pkg::X_W-1:0]             o_position,
    output logic [hti_pkg::X_W-1:0]             o_velocity,
    output logic [1:0]                          o_order_used,
    output logic                                o_divide_error
);

    localparam int S = hti_pkg::DIV_STAGES;
    localparam int W = hti_pkg::DIV_W;
    localparam int MAG_W = 48;

    logic                        r_val  [0:S];
    logic [W-1:0]                r_rem  [0:S];
    logic [W-1:0]                r_lq   [0:S];
    logic [hti_pkg::DT_W-1:0]    r_dt   [0:S];
    logic                        r_ovf  [0:S];
    logic                        r_neg  [0:S];
    logic                        r_zero [0:S];
    logic                        r_cub  [0:S];
    logic                        r_err  [0:S];
    logic [hti_pkg::X_W-1:0]     r_vnc  [0:S];
    logic [hti_pkg::X_W-1:0]     r_pos  [0:S];
    hti_pkg::t_order             r_ord  [0:S];
    logic [W-1:0]                n_rem  [1:S];
    logic [W-1:0]                n_lq   [1:S];

    // prep: magnitude capped at 2^47, numerator = mag << 16
    logic [hti_pkg::ACC_W-1:0]   n_mag;
    logic [MAG_W-1:0]            n_cap;
    logic [2*W-1:0]              n_num;

    always_comb begin
        n_mag = (i_vacc < 0) ? hti_pkg::ACC_W'(-i_vacc) : hti_pkg::ACC_W'(i_vacc);
        n_cap = (n_mag > hti_pkg::ACC_W'({1'b1, 47'd0})) ? {1'b1, 47'd0} : n_mag[MAG_W-1:0];
        n_num = {n_cap, 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_val[0] <= 1'b0;
        else r_val[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_num[2*W-1:W];
        r_lq[0]   <= n_num[W-1:0];
        r_dt[0]   <= i_dt;
        r_ovf[0]  <= n_num[2*W-1:W] >= {1'b0, i_dt};
        r_neg[0]  <= i_vacc < 0;
        r_zero[0] <= i_vacc == '0;
        r_cub[0]  <= i_order == hti_pkg::ORD_CUBIC;
        r_err[0]  <= (i_order == hti_pkg::ORD_CUBIC) && (i_dt == '0);
        r_vnc[0]  <= hti_pkg::sat32(i_vacc);
        r_pos[0]  <= hti_pkg::sat32(i_pacc);
        r_ord[0]  <= i_order;
    end

    for (genvar g = 1; g <= S; g++) begin : g_stage
        always_comb begin : div_bits
            logic [W-1:0] rem;
            logic [W-1:0] lq;
            logic [W-1:0] tmp;
            rem = r_rem[g-1];
            lq  = r_lq[g-1];
            for (int b = 0; b < hti_pkg::DIV_PER; b++) begin
                tmp = {rem[W-2:0], lq[W-1]};
                lq  = {lq[W-2:0], 1'b0};
                if (tmp >= {1'b0, r_dt[g-1]}) begin
                    tmp   = tmp - {1'b0, r_dt[g-1]};
                    lq[0] = 1'b1;
                end
                rem = tmp;
            end
            n_rem[g] = rem;
            n_lq[g]  = lq;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_val[g] <= 1'b0;
            else r_val[g] <= r_val[g-1];
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem[g];
            r_lq[g]   <= n_lq[g];
            r_dt[g]   <= r_dt[g-1];
            r_ovf[g]  <= r_ovf[g-1];
            r_neg[g]  <= r_neg[g-1];
            r_zero[g] <= r_zero[g-1];
            r_cub[g]  <= r_cub[g-1];
            r_err[g]  <= r_err[g-1];
            r_vnc[g]  <= r_vnc[g-1];
            r_pos[g]  <= r_pos[g-1];
            r_ord[g]  <= r_ord[g-1];
        end
    end

    logic [hti_pkg::X_W-1:0] n_vel;
    logic [W-1:0]            q;

    always_comb begin
        q = r_lq[S];
        if (!r_cub[S]) begin
            n_vel = r_vnc[S];
        end else if (r_err[S]) begin
            n_vel = r_neg[S] ? 32'h8000_0000 : (r_zero[S] ? 32'h0 : 32'h7FFF_FFFF);
        end else if (r_neg[S]) begin
            n_vel = (r_ovf[S] || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end else begin
            n_vel = (r_ovf[S] || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
    end

    logic                    r_o_valid;
    logic [hti_pkg::X_W-1:0] r_o_pos, r_o_vel;
    logic [1:0]              r_o_ord;
    logic                    r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else r_o_valid <= r_val[S];
    end

    always_ff @(posedge i_clk) begin
        r_o_pos <= r_pos[S];
        r_o_vel <= n_vel;
        r_o_ord <= r_ord[S];
        r_o_err <= r_err[S];
    end

    assign o_valid        = r_o_valid;
    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_order_used   = r_o_ord;
    assign o_divide_error = r_o_err;

endmodule

// ===== rtl/hermite_trajectory_interpolator.sv =====
// Top level of the Hermite trajectory interpolator: coefficient front end, Horner steps, divider.
//
//  channel   | ports                                   | beat taken when
//  ----------+-----------------------------------------+-------------------------
//  segment   | i_start, o_busy, i_time_step .. i_fraction | i_start && !o_busy
//  result    | o_valid, o_position .. o_divide_error   | every cycle o_valid is high
//  config    | i_cfg_we, i_cfg_data                     | i_cfg_we
//
//  One segment beat per cycle, sustained; o_busy stays low.
//  From accept to the result strobe the path runs through four front-end stages
//  and a coefficient register, three Horner steps of three stages each (multiply,
//  hi/lo combine, add), then the divider: a prep stage, sixteen stages of two
//  quotient bits each and the output register.
//  Reset (synchronous, active low) clears the valid chain and sets the tolerance to 17.
//  The receiver cannot stall; each result shows for exactly one cycle.
module hermite_trajectory_interpolator #(
    parameter int FRACTION_BITS = hti_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_cfg_we,
    input  logic [hti_pkg::TOL_W-1:0]          i_cfg_data,
    input  logic [hti_pkg::DT_W-1:0]           i_time_step,
    input  logic signed [hti_pkg::X_W-1:0]     i_start_position,
    input  logic signed [hti_pkg::X_W-1:0]     i_start_velocity,
    input  logic signed [hti_pkg::X_W-1:0]     i_end_position,
    input  logic signed [hti_pkg::X_W-1:0]     i_end_velocity,
    input  logic [1:0]                         i_forced_order,
    input  logic signed [hti_pkg::K_W-1:0]     i_fraction,
    output logic                               o_valid,
    output logic signed [hti_pkg::X_W-1:0]     o_position,
    output logic signed [hti_pkg::X_W-1:0]     o_velocity,
    output logic [1:0]                         o_order_used,
    output logic                               o_divide_error
);

    localparam int LATENCY = 32;
    localparam int VW = hti_pkg::VDT_W;
    localparam int SW = hti_pkg::SPAN_W;
    localparam int CW = hti_pkg::CO_W;

    assign o_busy = 1'b0;

    // degeneracy tolerance register
    logic [hti_pkg::TOL_W-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tol <= hti_pkg::TOL_RESET;
        else if (i_cfg_we) r_tol <= i_cfg_data;
    end

    // ---- stage 1: capture the segment beat
    logic                          r1_valid;
    logic [hti_pkg::DT_W-1:0]      r1_dt;
    logic signed [hti_pkg::X_W-1:0] r1_x1, r1_v1, r1_x2, r1_v2;
    hti_pkg::t_order               r1_ord;
    logic signed [hti_pkg::K_W-1:0] r1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else r1_valid <= i_start && !o_busy;
    end

    always_ff @(posedge i_clk) begin
        r1_dt  <= i_time_step;
        r1_x1  <= i_start_position;
        r1_v1  <= i_start_velocity;
        r1_x2  <= i_end_position;
        r1_v2  <= i_end_velocity;
        r1_ord <= hti_pkg::t_order'(i_forced_order);
        r1_k   <= i_fraction;
    end

    // ---- stage 2: v*dt products, span and its magnitude, velocity difference
    logic signed [63:0]  n2_p1, n2_p2;
    logic signed [SW-1:0] n2_span;

    always_comb begin
        n2_p1   = $signed(r1_v1) * $signed({1'b0, r1_dt});
        n2_p2   = $signed(r1_v2) * $signed({1'b0, r1_dt});
        n2_span = SW'(r1_x2) - SW'(r1_x1);
    end

    logic                           r2_valid;
    logic signed [VW-1:0]           r2_v1dt, r2_v2dt;
    logic signed [SW-1:0]           r2_span, r2_vdiff;
    logic [SW-1:0]                  r2_aspan;
    logic signed [hti_pkg::X_W-1:0] r2_x1, r2_v1;
    logic [hti_pkg::DT_W-1:0]       r2_dt;
    hti_pkg::t_order                r2_ord;
    logic signed [hti_pkg::K_W-1:0] r2_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else r2_valid <= r1_valid;
    end

    always_ff @(posedge i_clk) begin
        r2_v1dt  <= $signed(n2_p1[62:16]);
        r2_v2dt  <= $signed(n2_p2[62:16]);
        r2_span  <= n2_span;
        r2_aspan <= (n2_span < 0) ? SW'(-n2_span) : SW'(n2_span);
        r2_vdiff <= SW'(r1_v2) - SW'(r1_v1);
        r2_x1    <= r1_x1;
        r2_v1    <= r1_v1;
        r2_dt    <= r1_dt;
        r2_ord   <= r1_ord;
        r2_k     <= r1_k;
    end

    // ---- stage 3: cubic/quadratic coefficients, tolerance times span
    logic signed [CW-1:0] n3_span, n3_v1, n3_v2;
    always_comb begin
        n3_span = CW'(r2_span);
        n3_v1   = CW'(r2_v1dt);
        n3_v2   = CW'(r2_v2dt);
    end

    logic                           r3_valid;
    logic signed [CW-1:0]           r3_ca, r3_qa, r3_cb;
    logic [hti_pkg::TPR_W-1:0]      r3_tprod;
    logic signed [VW-1:0]           r3_v1dt;
    logic signed [SW-1:0]           r3_span, r3_vdiff;
    logic signed [hti_pkg::X_W-1:0] r3_x1, r3_v1;
    logic [hti_pkg::DT_W-1:0]       r3_dt;
    hti_pkg::t_order                r3_ord;
    logic signed [hti_pkg::K_W-1:0] r3_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else r3_valid <= r2_valid;
    end

    always_ff @(posedge i_clk) begin
        r3_ca    <= n3_v2 + n3_v1 - (n3_span <<< 1);
        r3_qa    <= n3_span - n3_v1;
        r3_cb    <= (n3_span <<< 1) + n3_span - (n3_v1 <<< 1) - n3_v2;
        r3_tprod <= r_tol * r2_aspan;
        r3_v1dt  <= r2_v1dt;
        r3_span  <= r2_span;
        r3_vdiff <= r2_vdiff;
        r3_x1    <= r2_x1;
        r3_v1    <= r2_v1;
        r3_dt    <= r2_dt;
        r3_ord   <= r2_ord;
        r3_k     <= r2_k;
    end

    // ---- stage 4: ceil(tol*|span| / 2^24) and leading-term magnitudes
    logic [hti_pkg::TPR_W:0] n4_tsum;
    always_comb begin
        n4_tsum = {1'b0, r3_tprod} + (hti_pkg::TPR_W+1)'(24'hFF_FFFF);
    end

    logic                           r4_valid;
    logic [hti_pkg::THR_W-1:0]      r4_thr;
    logic [CW-1:0]                  r4_aca, r4_aqa;
    logic signed [CW-1:0]           r4_ca, r4_qa, r4_cb;
    logic signed [VW-1:0]           r4_v1dt;
    logic signed [SW-1:0]           r4_span, r4_vdiff;
    logic signed [hti_pkg::X_W-1:0] r4_x1, r4_v1;
    logic [hti_pkg::DT_W-1:0]       r4_dt;
    hti_pkg::t_order                r4_ord;
    logic signed [hti_pkg::K_W-1:0] r4_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else r4_valid <= r3_valid;
    end

    always_ff @(posedge i_clk) begin
        r4_thr   <= n4_tsum[hti_pkg::TPR_W:hti_pkg::SPLIT];
        r4_aca   <= (r3_ca < 0) ? CW'(-r3_ca) : CW'(r3_ca);
        r4_aqa   <= (r3_qa < 0) ? CW'(-r3_qa) : CW'(r3_qa);
        r4_ca    <= r3_ca;
        r4_qa    <= r3_qa;
        r4_cb    <= r3_cb;
        r4_v1dt  <= r3_v1dt;
        r4_span  <= r3_span;
        r4_vdiff <= r3_vdiff;
        r4_x1    <= r3_x1;
        r4_v1    <= r3_v1;
        r4_dt    <= r3_dt;
        r4_ord   <= r3_ord;
        r4_k     <= r3_k;
    end

    // ---- stage 5: pick the order, load the Horner coefficients
    // Lower orders run the same three steps with leading zeros; the zero
    // steps pass the next coefficient through unchanged.
    hti_pkg::t_order              n5_ord;
    hti_pkg::t_job                n5_job;
    logic signed [hti_pkg::ACC_W-1:0] n5_pa;
    logic                         n5_small_c, n5_small_q;

    always_comb begin
        n5_small_c = r4_aca < CW'(r4_thr);
        n5_small_q = r4_aqa < CW'(r4_thr);
        n5_ord     = r4_ord;
        if (r4_ord == hti_pkg::ORD_AUTO) begin
            if (!n5_small_c) n5_ord = hti_pkg::ORD_CUBIC;
            else if (!n5_small_q) n5_ord = hti_pkg::ORD_QUAD;
            else n5_ord = hti_pkg::ORD_LINEAR;
        end
        n5_job.k     = r4_k;
        n5_job.dt    = r4_dt;
        n5_job.order = n5_ord;
        n5_job.pc[2] = CW'(r4_x1);
        n5_job.vc[0] = '0;
        n5_job.vc[1] = CW'(r4_vdiff);
        n5_job.vc[2] = CW'(r4_v1);
        n5_pa        = '0;
        unique case (n5_ord)
            hti_pkg::ORD_CUBIC: begin
                n5_pa        = hti_pkg::ACC_W'(r4_ca);
                n5_job.pc[0] = r4_cb;
                n5_job.pc[1] = CW'(r4_v1dt);
                n5_job.vc[0] = (r4_ca <<< 1) + r4_ca;
                n5_job.vc[1] = r4_cb <<< 1;
                n5_job.vc[2] = CW'(r4_v1dt);
            end
            hti_pkg::ORD_QUAD: begin
                n5_job.pc[0] = r4_qa;
                n5_job.pc[1] = CW'(r4_v1dt);
            end
            default: begin
                n5_job.pc[0] = '0;
                n5_job.pc[1] = CW'(r4_span);
            end
        endcase
    end

    logic                              r5_valid;
    hti_pkg::t_job                     r5_job;
    logic signed [hti_pkg::ACC_W-1:0]  r5_pa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_valid <= 1'b0;
        else r5_valid <= r4_valid;
    end

    always_ff @(posedge i_clk) begin
        r5_job <= n5_job;
        r5_pa  <= n5_pa;
    end

    // ---- Horner steps: position and velocity lanes side by side
    logic                              s_valid [0:3];
    hti_pkg::t_job                     s_job   [0:3];
    logic signed [hti_pkg::ACC_W-1:0]  s_pacc  [0:3];
    logic signed [hti_pkg::ACC_W-1:0]  s_vacc  [0:3];

    assign s_valid[0] = r5_valid;
    assign s_job[0]   = r5_job;
    assign s_pacc[0]  = r5_pa;
    assign s_vacc[0]  = '0;

    for (genvar g = 0; g < 3; g++) begin : g_horner
        hti_horner_step #(
            .FRACTION_BITS (FRACTION_BITS),
            .STEP          (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_job   (s_job[g]),
            .i_pacc  (s_pacc[g]),
            .i_vacc  (s_vacc[g]),
            .o_valid (s_valid[g+1]),
            .o_job   (s_job[g+1]),
            .o_pacc  (s_pacc[g+1]),
            .o_vacc  (s_vacc[g+1])
        );
    end

    // ---- divide by dt (cubic velocity), saturate, drive the result ports
    hti_divider u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_valid[3]),
        .i_vacc         (s_vacc[3]),
        .i_pacc         (s_pacc[3]),
        .i_order        (s_job[3].order),
        .i_dt           (s_job[3].dt),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_velocity     (o_velocity),
        .o_order_used   (o_order_used),
        .o_divide_error (o_divide_error)
    );

    // ---- checks
    a_order_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_order_used != 2'd0)
        else $error("result beat with order zero");

    a_err_cubic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_order_used == 2'd3)
        else $error("divide error on a non-cubic result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##LATENCY o_valid)
        else $error("segment beat without result beat");

    a_forced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_forced_order != 2'd0
        |-> ##LATENCY o_order_used == $past(i_forced_order, LATENCY))
        else $error("forced order not honored");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the Hermite trajectory interpolator top level.
module testbench;

    localparam int  FB       = hti_pkg::FRACTION_BITS_DEF;
    localparam int  LATENCY  = 32;
    localparam int  N_RANDOM = 1750;
    localparam longint LIMIT60 = 64'sd1 <<< 60;
    localparam longint MAX32   = 64'sd2147483647;
    localparam longint MIN32   = -64'sd2147483648;

    // one segment beat as driven on the input ports
    typedef struct packed {
        logic [hti_pkg::DT_W-1:0]        dt;
        logic signed [hti_pkg::X_W-1:0]  x1;
        logic signed [hti_pkg::X_W-1:0]  v1;
        logic signed [hti_pkg::X_W-1:0]  x2;
        logic signed [hti_pkg::X_W-1:0]  v2;
        hti_pkg::t_order                 ord;
        logic signed [hti_pkg::K_W-1:0]  k;
    } t_seg;

    // one result beat
    typedef struct packed {
        logic signed [hti_pkg::X_W-1:0]  pos;
        logic signed [hti_pkg::X_W-1:0]  vel;
        logic [1:0]                      ord;
        logic                            err;
    } t_res;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           cfg_we;
    logic [hti_pkg::TOL_W-1:0]      cfg_data;
    logic [hti_pkg::DT_W-1:0]       time_step;
    logic signed [hti_pkg::X_W-1:0] start_position, start_velocity, end_position, end_velocity;
    logic [1:0]                     forced_order;
    logic signed [hti_pkg::K_W-1:0] fraction;
    logic                           valid;
    logic signed [hti_pkg::X_W-1:0] position, velocity;
    logic [1:0]                     order_used;
    logic                           divide_error;

    t_seg segments_pending[$];
    t_res results_expected[$];
    longint tolerance;      // predictor copy of the register
    bit     idle_on;        // sender gap insertion enable
    bit     hold_sender;    // sender pauses entirely
    bit     accepted;       // beat taken at the last rising edge
    int     fail_count;

    hermite_trajectory_interpolator uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_time_step(time_step), .i_start_position(start_position),
        .i_start_velocity(start_velocity), .i_end_position(end_position),
        .i_end_velocity(end_velocity), .i_forced_order(forced_order),
        .i_fraction(fraction), .o_valid(valid), .o_position(position),
        .o_velocity(velocity), .o_order_used(order_used),
        .o_divide_error(divide_error)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic longint floor_div_pow2(longint x, int n);
        return x >>> n;     // arithmetic shift is floor division
    endfunction

    function automatic longint clamp60(longint x);
        if (x > LIMIT60) return LIMIT60;
        if (x < -LIMIT60) return -LIMIT60;
        return x;
    endfunction

    function automatic longint sat_word(longint x);
        if (x > MAX32) return MAX32;
        if (x < MIN32) return MIN32;
        return x;
    endfunction

    // floor(a*k / 2^FB) without overflowing 64 bits, clamped to +-2^60
    function automatic longint scale_by_k(longint a, longint k);
        longint hi, lo, p, r, lim;
        hi  = floor_div_pow2(a, 24);
        lo  = a - (hi <<< 24);
        p   = hi * k;
        lim = LIMIT60 >>> (24 - FB);
        if (p > lim) r = LIMIT60;
        else if (p < -lim) r = -LIMIT60;
        else r = p <<< (24 - FB);
        return clamp60(r + floor_div_pow2(lo * k, FB));
    endfunction

    // leading term small against span: |lead|*2^24 < tol*|span|
    function automatic bit lead_is_small(longint lead, longint span);
        longint unsigned al, as, t, q;
        al = lead < 0 ? -lead : lead;
        as = span < 0 ? -span : span;
        t  = tolerance * as;
        q  = (t + 64'd16777215) >> 24;
        return al < q;
    endfunction

    function automatic t_res interpolate(t_seg s);
        longint dt, x1, v1, x2, v2, k, v1dt, v2dt, span, ca, qa, cb, t, pos, vel;
        longint unsigned m, q;
        logic [1:0] ord;
        t_res r;
        dt = s.dt; x1 = s.x1; v1 = s.v1; x2 = s.x2; v2 = s.v2; k = s.k;
        ord  = s.ord;
        v1dt = floor_div_pow2(v1 * dt, 16);
        v2dt = floor_div_pow2(v2 * dt, 16);
        span = x2 - x1;
        ca   = v2dt + v1dt - 2 * span;
        qa   = span - v1dt;
        r.err = 1'b0;
        if (ord == hti_pkg::ORD_AUTO) begin
            if (!lead_is_small(ca, span)) ord = hti_pkg::ORD_CUBIC;
            else if (!lead_is_small(qa, span)) ord = hti_pkg::ORD_QUAD;
            else ord = hti_pkg::ORD_LINEAR;
        end
        if (ord == hti_pkg::ORD_CUBIC) begin
            cb  = 3 * span - 2 * v1dt - v2dt;
            t   = clamp60(scale_by_k(ca, k) + cb);
            t   = clamp60(scale_by_k(t, k) + v1dt);
            pos = sat_word(clamp60(scale_by_k(t, k) + x1));
            t   = clamp60(scale_by_k(3 * ca, k) + 2 * cb);
            t   = clamp60(scale_by_k(t, k) + v1dt);
            if (dt == 0) begin
                r.err = 1'b1;
                vel = t > 0 ? MAX32 : (t < 0 ? MIN32 : 0);
            end else begin
                m = t < 0 ? -t : t;
                if (m > (64'd1 << 47)) m = 64'd1 << 47;
                q = (m << 16) / longint'(dt);
                if (t < 0) vel = q > 64'd2147483648 ? MIN32 : -longint'(q);
                else vel = q > 64'd2147483647 ? MAX32 : longint'(q);
            end
        end else begin
            if (ord == hti_pkg::ORD_QUAD) begin
                t   = clamp60(scale_by_k(qa, k) + v1dt);
                pos = sat_word(clamp60(scale_by_k(t, k) + x1));
            end else begin
                pos = sat_word(clamp60(scale_by_k(span, k) + x1));
            end
            vel = sat_word(clamp60(scale_by_k(v2 - v1, k) + v1));
        end
        r.pos = pos[31:0];
        r.vel = vel[31:0];
        r.ord = ord;
        return r;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk) accepted <= rst_n && start && !busy;

    // a held beat stays put until taken; start stays high back to back
    always @(negedge clk) begin
        t_seg s;
        bit   go;
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || accepted) begin
            go = (segments_pending.size() != 0) && !hold_sender &&
                 (!idle_on || $urandom_range(99) >= 38);
            if (go) begin
                s = segments_pending.pop_front();
                time_step <= s.dt;          start_position <= s.x1;
                start_velocity <= s.v1;     end_position <= s.x2;
                end_velocity <= s.v2;       forced_order <= s.ord;
                fraction <= s.k;
                start <= 1'b1;
                results_expected.push_back(interpolate(s));
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        t_res e;
        if (rst_n && valid) begin
            if (results_expected.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                e = results_expected.pop_front();
                if (position !== e.pos) begin
                    $error("position expected %0d got %0d", e.pos, position);
                    fail_count++;
                end
                if (velocity !== e.vel) begin
                    $error("velocity expected %0d got %0d", e.vel, velocity);
                    fail_count++;
                end
                if (order_used !== e.ord) begin
                    $error("order_used expected %0d got %0d", e.ord, order_used);
                    fail_count++;
                end
                if (divide_error !== e.err) begin
                    $error("divide_error expected %0d got %0d", e.err, divide_error);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(65535) - 32768;           // small
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            3: return 32'h8000_0000 + $urandom_range(3);
            default: return ($urandom_range(1 << 22) - (1 << 21)) <<< 2;
        endcase
    endfunction

    function automatic t_seg random_segment();
        t_seg s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) s.dt = '0;
        else if (pick < 10) s.dt = 31'h7FFF_FFFF;
        else if (pick < 50) s.dt = 31'($urandom());
        else s.dt = 31'($urandom_range(1 << 20));
        s.x1 = rand_word($urandom_range(5));
        s.v1 = rand_word($urandom_range(5));
        // near-degenerate segments exercise the order drop
        if ($urandom_range(3) == 0) begin
            s.x2 = s.x1 + 32'($urandom_range(1 << 16));
            s.v1 = '0;
            s.v2 = 32'($urandom_range(3)) - 32'd1;
        end else begin
            s.x2 = rand_word($urandom_range(5));
            s.v2 = rand_word($urandom_range(5));
        end
        s.ord = hti_pkg::t_order'($urandom_range(3));
        s.k   = 18'($urandom());
        return s;
    endfunction

    function automatic t_seg directed(logic [hti_pkg::DT_W-1:0] dt, longint x1, longint v1,
                                      longint x2, longint v2, hti_pkg::t_order o,
                                      longint k);
        t_seg s;
        s.dt = dt; s.x1 = 32'(x1); s.v1 = 32'(v1); s.x2 = 32'(x2); s.v2 = 32'(v2);
        s.ord = o; s.k = 18'(k);
        return s;
    endfunction

    // wait until every expected beat has come, plus the pipeline tail
    task automatic drain();
        while (segments_pending.size() != 0 || start || results_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [hti_pkg::TOL_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        tolerance = longint'(v);
    endtask

    initial begin
        logic [hti_pkg::TOL_W-1:0] tol_set[4];
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_data = '0;
        time_step = '0; start_position = '0; start_velocity = '0;
        end_position = '0; end_velocity = '0; forced_order = '0; fraction = '0;
        tolerance = 17; idle_on = 1'b1; hold_sender = 1'b0; fail_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: extremes, every order, zero time step, equal ends
        for (int o = 0; o < 4; o++) begin
            segments_pending.push_back(directed(31'h10000, 0, 65536, 65536, 65536,
                                                hti_pkg::t_order'(o), 32768));
            segments_pending.push_back(directed(0, 100, 200, 300, -50,
                                                hti_pkg::t_order'(o), 65536));
            segments_pending.push_back(directed(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                                32'h8000_0000, 32'h7FFF_FFFF,
                                                hti_pkg::t_order'(o), 131071));
            segments_pending.push_back(directed(31'h7FFF_FFFF, MIN32, MIN32, MAX32, MIN32,
                                                hti_pkg::t_order'(o), -131072));
            segments_pending.push_back(directed(12345, 777, 5, 777, -5,
                                                hti_pkg::t_order'(o), -1));
        end
        segments_pending.push_back(directed(0, 0, 0, 0, 0, hti_pkg::ORD_CUBIC, 0));
        segments_pending.push_back(directed(65536, 0, 0, 1 << 20, 0, hti_pkg::ORD_AUTO,
                                            40000));
        drain();

        // tolerance sweep, extremes included; sender pauses between phases
        tol_set = '{16'd0, 16'hFFFF, 16'd17, 16'd4000};
        foreach (tol_set[p]) begin
            write_tolerance(tol_set[p]);
            idle_on = (p != 2);     // one phase with no sender gaps at all
            for (int n = 0; n < N_RANDOM / 4; n++)
                segments_pending.push_back(random_segment());
            if (p == 1) begin
                repeat (200) @(posedge clk);
                hold_sender = 1'b1;
                while (results_expected.size() != 0) @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hti_pkg.sv
rtl/hti_horner_step.sv
rtl/hti_divider.sv
rtl/hermite_trajectory_interpolator.sv
verif/testbench.sv
